/* rtl/core/srce_pkg.sv */
// srce_pkg: shared types and constants for the sample rate-of-change estimator.
// Used by srce_div and sample_rate_of_change_estimator_unit; no dependencies.

package srce_pkg;

    localparam int DATA_W    = 32;          // sample, timestamp and rate width
    localparam int NUM_W     = DATA_W + 1;  // signed dividend: difference of two 32-bit values
    localparam int QUO_W     = DATA_W;      // quotient magnitude (|dividend| < 2^32)
    localparam int STEP_W    = $clog2(QUO_W);
    localparam int PREC_W    = 31;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION    = 2'd2;

    localparam logic [DATA_W-1:0] MAX_INTERVAL_RST = 32'd10000;
    localparam logic [DATA_W-1:0] POS_LIMIT        = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] NEG_LIMIT        = 32'h8000_0000;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_CHECK,
        ST_DIV1,
        ST_DIFF,
        ST_LOAD2,
        ST_DIV2,
        ST_DONE
    } srce_state_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [DATA_W-1:0] tstamp;
        logic [DATA_W-1:0] rate;
    } srce_entry_t;

endpackage

/* rtl/core/sample_rate_of_change_estimator_unit.sv */
// sample_rate_of_change_estimator_unit: per-channel first/second derivative
// with interval and dead-band gating. Depends on srce_pkg and srce_div.
//
// Usage:
//   Input channel (in_valid/in_ready) carries group_index, channel_index,
//   sample_value (Q16.16) and sample_time (wrapping ticks). Output channel
//   (out_valid/out_ready) returns exactly one result per input transfer:
//   updated, rate_valid, first_derivative, second_derivative.
//   Configuration is a write port (cfg_write_en, cfg_index, cfg_data):
//   0 = min_interval, 1 = max_interval, 2 = precision; other indexes ignored.
//   Items are processed one at a time. An updated item with nonzero elapsed
//   time runs up to two 32-step divisions on one shared radix-2 divider; the
//   second is skipped when the first rate is out of range. An item with no
//   update or an out-of-range address skips the divisions.
//   Channel history lives in one memory of GROUPS*CHANNELS_PER_GROUP entries.
//   After reset a clearing pass zeroes it, one entry per cycle, and in_ready
//   stays low until it finishes.
//   A finished result sits in an output register; if the receiver stalls the
//   block holds its next result until the register frees, and accepts no
//   further input until then.

module sample_rate_of_change_estimator_unit #(
    parameter int GROUPS             = 8,
    parameter int CHANNELS_PER_GROUP = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              cfg_write_en,
    input  logic [srce_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [srce_pkg::DATA_W-1:0]       cfg_data,

    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [2:0]                        group_index,
    input  logic [3:0]                        channel_index,
    input  logic signed [srce_pkg::DATA_W-1:0] sample_value,
    input  logic [srce_pkg::DATA_W-1:0]       sample_time,

    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              updated,
    output logic                              rate_valid,
    output logic signed [srce_pkg::DATA_W-1:0] first_derivative,
    output logic signed [srce_pkg::DATA_W-1:0] second_derivative
);
    import srce_pkg::*;

    localparam int DEPTH  = GROUPS * CHANNELS_PER_GROUP;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

    srce_state_t state_reg, state_next;

    logic [DATA_W-1:0] min_interval_reg;
    logic [DATA_W-1:0] max_interval_reg;
    logic [PREC_W-1:0] precision_reg;

    logic [ADDR_W-1:0] clr_addr_reg;
    logic [ADDR_W-1:0] addr_reg;
    logic [DATA_W-1:0] sample_reg;
    logic [DATA_W-1:0] time_reg;
    srce_entry_t       entry_reg;
    logic [DATA_W-1:0] elapsed_reg;
    logic [NUM_W-1:0]  delta_reg;
    logic [NUM_W-1:0]  dr_reg;
    logic [DATA_W-1:0] d1_reg;
    logic [DATA_W-1:0] d2_reg;
    logic              upd_reg;
    logic              valid_reg;

    logic              out_valid_reg;
    logic              out_upd_reg;
    logic              out_rv_reg;
    logic [DATA_W-1:0] out_d1_reg;
    logic [DATA_W-1:0] out_d2_reg;

    srce_entry_t       mem [DEPTH];
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    srce_entry_t       mem_wdata;

    logic              in_xfer;
    logic              in_range;
    logic [ADDR_W-1:0] in_addr;
    logic              out_free;

    logic [NUM_W-1:0]  abs_delta;
    logic              upd;
    logic              elapsed_zero;

    logic              div_start;
    logic [NUM_W-1:0]  div_num;
    logic              div_done;
    logic              div_neg;
    logic [QUO_W-1:0]  div_quo;
    logic              fits;
    logic [DATA_W-1:0] quo_signed;

    assign in_xfer  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign in_range = (int'(group_index) < GROUPS) && (int'(channel_index) < CHANNELS_PER_GROUP);
    assign in_addr  = ADDR_W'(int'(group_index) * CHANNELS_PER_GROUP + int'(channel_index));

    // gating test
    assign abs_delta    = delta_reg[NUM_W-1] ? NUM_W'(-delta_reg) : delta_reg;
    assign elapsed_zero = (elapsed_reg == '0);
    assign upd = ((elapsed_reg > min_interval_reg) && (abs_delta > NUM_W'(precision_reg)))
                 || (elapsed_reg > max_interval_reg);

    // quotient range check and sign restore, shared by both divisions
    assign fits       = div_neg ? (div_quo <= NEG_LIMIT) : (div_quo <= POS_LIMIT);
    assign quo_signed = div_neg ? (DATA_W'(0) - div_quo) : div_quo;

    assign div_num = (state_reg == ST_CHECK) ? delta_reg : dr_reg;

    srce_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (elapsed_reg),
        .done  (div_done),
        .neg   (div_neg),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        div_start  = 1'b0;
        mem_we     = 1'b0;
        mem_waddr  = addr_reg;
        mem_wdata  = '{value: sample_reg, tstamp: time_reg,
                       rate: valid_reg ? d1_reg : entry_reg.rate};
        unique case (state_reg)
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_addr_reg;
                mem_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    state_next = in_range ? ST_READ : ST_DONE;
            end
            ST_READ:
                state_next = ST_EVAL;
            ST_EVAL:
                state_next = ST_CHECK;
            ST_CHECK:
            begin
                if (upd && !elapsed_zero)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV1;
                end
                else
                    state_next = ST_DONE;
            end
            ST_DIV1:
            begin
                if (div_done)
                    state_next = fits ? ST_DIFF : ST_DONE;
            end
            ST_DIFF:
                state_next = ST_LOAD2;
            ST_LOAD2:
            begin
                div_start  = 1'b1;
                state_next = ST_DIV2;
            end
            ST_DIV2:
            begin
                if (div_done)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    mem_we     = upd_reg;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_interval_reg <= '0;
            max_interval_reg <= MAX_INTERVAL_RST;
            precision_reg    <= '0;
            clr_addr_reg     <= '0;
            upd_reg          <= 1'b0;
            valid_reg        <= 1'b0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                case (cfg_index)
                    CFG_MIN_INTERVAL: min_interval_reg <= cfg_data;
                    CFG_MAX_INTERVAL: max_interval_reg <= cfg_data;
                    CFG_PRECISION:    precision_reg    <= cfg_data[PREC_W-1:0];
                    default:          ;
                endcase
            end

            if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;

            if (in_xfer)
            begin
                upd_reg   <= 1'b0;
                valid_reg <= 1'b0;
            end
            else if (state_reg == ST_CHECK)
                upd_reg <= upd;
            else if (state_reg == ST_DIV2 && div_done)
                valid_reg <= 1'b1;

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            addr_reg   <= in_addr;
            sample_reg <= sample_value;
            time_reg   <= sample_time;
        end
        if (state_reg == ST_EVAL)
        begin
            elapsed_reg <= time_reg - entry_reg.tstamp;
            delta_reg   <= {sample_reg[DATA_W-1], sample_reg}
                           - {entry_reg.value[DATA_W-1], entry_reg.value};
        end
        if (state_reg == ST_DIV1 && div_done)
            d1_reg <= quo_signed;
        if (state_reg == ST_DIFF)
            dr_reg <= {d1_reg[DATA_W-1], d1_reg} - {entry_reg.rate[DATA_W-1], entry_reg.rate};
        if (state_reg == ST_DIV2 && div_done)
        begin
            if (fits)
                d2_reg <= quo_signed;
            else
                d2_reg <= div_neg ? NEG_LIMIT : POS_LIMIT;
        end
        if (state_reg == ST_DONE && out_free)
        begin
            out_upd_reg <= upd_reg;
            out_rv_reg  <= valid_reg;
            out_d1_reg  <= valid_reg ? d1_reg : '0;
            out_d2_reg  <= valid_reg ? d2_reg : '0;
        end
    end

    // channel history memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        entry_reg <= mem[addr_reg];
    end

    assign out_valid         = out_valid_reg;
    assign updated           = out_upd_reg;
    assign rate_valid        = out_rv_reg;
    assign first_derivative  = out_d1_reg;
    assign second_derivative = out_d2_reg;

endmodule

/* rtl/core/srce_div.sv */
// srce_div: radix-2 restoring divider, signed dividend by unsigned divisor,
// truncating toward zero; result as sign and magnitude. Depends on srce_pkg.

module srce_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [srce_pkg::NUM_W-1:0] num,
    input  logic [srce_pkg::DATA_W-1:0] den,
    output logic                        done,
    output logic                        neg,
    output logic [srce_pkg::QUO_W-1:0]  quo
);
    import srce_pkg::*;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(QUO_W - 1);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] den_reg;
    logic              neg_reg;

    logic [NUM_W-1:0]  num_abs;
    logic [DATA_W:0]   partial;
    logic [DATA_W:0]   trial;
    logic              qbit;

    assign num_abs = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);

    // partial < 2*den, so the trial difference fits and its top bit is the borrow
    assign partial = {rem_reg, quo_reg[QUO_W-1]};
    assign trial   = partial - {1'b0, den_reg};
    assign qbit    = ~trial[DATA_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == LAST_STEP);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                if (step_reg == LAST_STEP)
                    busy_reg <= 1'b0;
                step_reg <= step_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num_abs[QUO_W-1:0];
            rem_reg <= '0;
            den_reg <= den;
            neg_reg <= num[NUM_W-1];
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[QUO_W-2:0], qbit};
            rem_reg <= qbit ? trial[DATA_W-1:0] : partial[DATA_W-1:0];
        end
    end

    assign done = done_reg;
    assign neg  = neg_reg;
    assign quo  = quo_reg;

endmodule

/* bench/tb_sample_rate_of_change_estimator_unit.sv */
// Testbench for sample_rate_of_change_estimator_unit: directed table, then random sample
// streams checked against a behavioral rate predictor. Depends on srce_pkg and the RTL.
`timescale 1ns / 100ps

module tb_sample_rate_of_change_estimator_unit;

    import srce_pkg::*;

    localparam int     CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 80;    // one full two-divide item and then some
    localparam int     CHAN_COUNT    = 128;
    localparam longint RATE_MAX      = 64'sd2147483647;
    localparam longint RATE_MIN      = -RATE_MAX - 1;

    typedef struct packed {
        logic              updated;
        logic              rate_valid;
        logic [DATA_W-1:0] first_rate;
        logic [DATA_W-1:0] second_rate;
    } rate_result_t;

    typedef struct packed {
        logic                 is_write;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [DATA_W-1:0]    reg_val;
        logic [2:0]           grp;
        logic [3:0]           chn;
        logic [DATA_W-1:0]    val;
        logic [DATA_W-1:0]    stamp;
        logic                 known;
        rate_result_t         want;
    } stim_row_t;

    typedef enum int {
        PROF_DEFAULT,
        PROF_ALWAYS,
        PROF_NEVER,
        PROF_MODERATE,
        PROF_WILD
    } cfg_profile_t;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write_en = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [DATA_W-1:0]         cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic [2:0]                group_index = '0;
    logic [3:0]                channel_index = '0;
    logic signed [DATA_W-1:0]  sample_value = '0;
    logic [DATA_W-1:0]         sample_time = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic                      updated;
    logic                      rate_valid;
    logic signed [DATA_W-1:0]  first_derivative;
    logic signed [DATA_W-1:0]  second_derivative;

    // predictor copy of registers and channel history
    logic [DATA_W-1:0]  min_gap = '0;
    logic [DATA_W-1:0]  max_gap = MAX_INTERVAL_RST;
    logic [PREC_W-1:0]  dead_band = '0;
    logic [DATA_W-1:0]  hist_value [CHAN_COUNT];
    logic [DATA_W-1:0]  hist_time  [CHAN_COUNT];
    logic [DATA_W-1:0]  hist_rate  [CHAN_COUNT];

    // what the stimulus last sent per channel, to build coherent streams
    logic [DATA_W-1:0]  sent_value [CHAN_COUNT];
    logic [DATA_W-1:0]  sent_time  [CHAN_COUNT];
    logic [6:0]         hot_chan [6] = '{7'd0, 7'd17, 7'd42, 7'd85, 7'd100, 7'd127};

    rate_result_t       pending_rates [$];
    stim_row_t          directed_rows [$];
    int                 fail_count = 0;
    int                 cycle_count = 0;
    int unsigned        send_idle_pct = 0;
    int unsigned        recv_idle_pct = 0;
    logic               valid_up = 1'b0;

    sample_rate_of_change_estimator_unit DUT (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write_en      (cfg_write_en),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .group_index       (group_index),
        .channel_index     (channel_index),
        .sample_value      (sample_value),
        .sample_time       (sample_time),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .updated           (updated),
        .rate_valid        (rate_valid),
        .first_derivative  (first_derivative),
        .second_derivative (second_derivative)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Finite-difference rates with interval / dead-band gating; updates history.
    function automatic rate_result_t estimate_rates(input logic [2:0] grp,
                                                    input logic [3:0] chn,
                                                    input logic [DATA_W-1:0] val,
                                                    input logic [DATA_W-1:0] now);
        rate_result_t      res;
        logic [6:0]        a;
        logic [DATA_W-1:0] elapsed;
        longint            delta;
        longint            abs_delta;
        longint            span;
        longint            q1;
        longint            q2;
        logic              moved;
        res = '0;
        a = {grp, chn};
        elapsed = now - hist_time[a];
        delta = longint'($signed(val)) - longint'($signed(hist_value[a]));
        abs_delta = (delta < 0) ? -delta : delta;
        moved = (elapsed > min_gap && abs_delta > longint'(dead_band)) || elapsed > max_gap;
        if (!moved)
            return res;
        res.updated = 1'b1;
        if (elapsed != 0)
        begin
            span = longint'(elapsed);
            q1 = delta / span;
            if (q1 >= RATE_MIN && q1 <= RATE_MAX)
            begin
                q2 = (q1 - longint'($signed(hist_rate[a]))) / span;
                if (q2 > RATE_MAX)
                    q2 = RATE_MAX;
                else if (q2 < RATE_MIN)
                    q2 = RATE_MIN;
                res.rate_valid  = 1'b1;
                res.first_rate  = q1[31:0];
                res.second_rate = q2[31:0];
                hist_rate[a] = q1[31:0];
            end
        end
        hist_value[a] = val;
        hist_time[a]  = now;
        return res;
    endfunction

    task automatic check_field(input string name, input logic [DATA_W-1:0] want,
                               input logic [DATA_W-1:0] got);
        if (want !== got)
        begin
            fail_count++;
            $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
        end
    endtask

    always @(posedge clk)
    begin : result_check
        rate_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_rates.size() == 0)
            begin
                fail_count++;
                $error("result transfer with no item outstanding");
            end
            else
            begin
                want = pending_rates.pop_front();
                check_field("updated", 32'(want.updated), 32'(updated));
                check_field("rate_valid", 32'(want.rate_valid), 32'(rate_valid));
                check_field("first_derivative", want.first_rate, first_derivative);
                check_field("second_derivative", want.second_rate, second_derivative);
            end
        end
    end

    // Drops valid unless it is already low; safe to call twice in one step.
    task automatic idle_input();
        if (valid_up)
        begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
    endtask

    task automatic wait_results();
        idle_input();
        while (pending_rates.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        wait_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] val);
        @(posedge clk);
        cfg_write_en <= 1'b1;
        cfg_index    <= idx;
        cfg_data     <= val;
        case (idx)
            CFG_MIN_INTERVAL: min_gap = val;
            CFG_MAX_INTERVAL: max_gap = val;
            CFG_PRECISION:    dead_band = val[PREC_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_write_en <= 1'b0;
    endtask

    // Valid stays high after the transfer; the next call either replaces the
    // payload in the same step or drops valid for a gap.
    task automatic send_sample(input logic [2:0] grp, input logic [3:0] chn,
                               input logic [DATA_W-1:0] val, input logic [DATA_W-1:0] now,
                               input logic use_known, input rate_result_t known);
        rate_result_t pred;
        if ($urandom_range(99) < send_idle_pct)
        begin
            idle_input();
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
        in_valid      <= 1'b1;
        valid_up      = 1'b1;
        group_index   <= grp;
        channel_index <= chn;
        sample_value  <= val;
        sample_time   <= now;
        do
            @(posedge clk);
        while (!in_ready);
        pred = estimate_rates(grp, chn, val, now);
        pending_rates.push_back(use_known ? known : pred);
    endtask

    function automatic void add_item(input logic [2:0] grp, input logic [3:0] chn,
                                     input logic [DATA_W-1:0] val,
                                     input logic [DATA_W-1:0] stamp, input logic known,
                                     input logic upd, input logic rv,
                                     input logic [DATA_W-1:0] d1,
                                     input logic [DATA_W-1:0] d2);
        stim_row_t row;
        row = '0;
        row.grp   = grp;
        row.chn   = chn;
        row.val   = val;
        row.stamp = stamp;
        row.known = known;
        row.want.updated     = upd;
        row.want.rate_valid  = rv;
        row.want.first_rate  = d1;
        row.want.second_rate = d2;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [DATA_W-1:0] val);
        stim_row_t row;
        row = '0;
        row.is_write = 1'b1;
        row.reg_idx  = idx;
        row.reg_val  = val;
        directed_rows.push_back(row);
    endfunction

    task automatic apply_profile(input cfg_profile_t prof);
        case (prof)
            PROF_DEFAULT:
            begin
                write_reg(CFG_MIN_INTERVAL, 32'd0);
                write_reg(CFG_MAX_INTERVAL, MAX_INTERVAL_RST);
                write_reg(CFG_PRECISION, 32'd0);
            end
            PROF_ALWAYS:
            begin
                write_reg(CFG_MIN_INTERVAL, 32'd0);
                write_reg(CFG_MAX_INTERVAL, 32'd0);
                write_reg(CFG_PRECISION, 32'd0);
            end
            PROF_NEVER:
            begin
                write_reg(CFG_MIN_INTERVAL, 32'hFFFF_FFFF);
                write_reg(CFG_MAX_INTERVAL, 32'hFFFF_FFFF);
                write_reg(CFG_PRECISION, 32'h7FFF_FFFF);
            end
            PROF_MODERATE:
            begin
                write_reg(CFG_MIN_INTERVAL, $urandom_range(100));
                write_reg(CFG_MAX_INTERVAL, $urandom_range(2000, 50));
                write_reg(CFG_PRECISION, $urandom_range(32'h30000));
            end
            default:
            begin
                write_reg(CFG_MIN_INTERVAL, $urandom);
                write_reg(CFG_MAX_INTERVAL, $urandom);
                write_reg(CFG_PRECISION, $urandom & 32'h7FFF_FFFF);
            end
        endcase
    endtask

    // Mostly coherent per-channel streams on a few busy channels; the rest is
    // long silences, one-tick full-scale jumps and raw noise.
    task automatic random_item();
        logic [6:0]        a;
        logic [DATA_W-1:0] step;
        logic [DATA_W-1:0] dv;
        int unsigned       roll;
        roll = $urandom_range(99);
        if ($urandom_range(99) < 65)
            a = hot_chan[$urandom_range(5)];
        else
            a = 7'($urandom);
        if (roll < 70)
        begin
            step = ($urandom_range(9) == 0) ? $urandom_range(3) : $urandom_range(400, 1);
            dv = $urandom & ((32'd1 << $urandom_range(24)) - 32'd1);
            if ($urandom_range(1) == 1)
                dv = -dv;
            sent_time[a]  = sent_time[a] + step;
            sent_value[a] = sent_value[a] + dv;
        end
        else if (roll < 80)
        begin
            sent_time[a]  = sent_time[a] + $urandom_range(200000, 5000);
            sent_value[a] = sent_value[a] ^ ($urandom & 32'h0000_FFFF);
        end
        else if (roll < 88)
        begin
            sent_time[a]  = sent_time[a] + 32'd1;
            sent_value[a] = sent_value[a] ^ 32'h8000_0000 ^ ($urandom & 32'h3);
        end
        else
        begin
            sent_time[a]  = $urandom;
            sent_value[a] = $urandom;
        end
        send_sample(a[6:4], a[3:0], sent_value[a], sent_time[a], 1'b0, '0);
    endtask

    initial
    begin
        for (int i = 0; i < CHAN_COUNT; i++)
        begin
            hist_value[i] = '0;
            hist_time[i]  = '0;
            hist_rate[i]  = '0;
            sent_value[i] = '0;
            sent_time[i]  = '0;
        end

        // reset-state items: first rate, dead-band hold, zero elapsed, wrap
        add_item(3'd0, 4'd0, 32'h0001_0000, 32'd100, 1'b1, 1'b1, 1'b1, 32'd655, 32'd6);
        add_item(3'd0, 4'd0, 32'h0001_0000, 32'd200, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd0, 4'd1, 32'h0000_0000, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd7, 4'd15, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0);
        add_item(3'd7, 4'd15, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
        // one-tick full-scale steps: rate limits, saturated second rate, overflow
        add_item(3'd1, 4'd0, 32'h8000_0000, 32'd1, 1'b1, 1'b1, 1'b1,
                 32'h8000_0000, 32'h8000_0000);
        add_item(3'd1, 4'd0, 32'hFFFF_FFFF, 32'd2, 1'b1, 1'b1, 1'b1,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(3'd1, 4'd1, 32'h7FFF_FFFF, 32'd1, 1'b1, 1'b1, 1'b1,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_item(3'd1, 4'd1, 32'hFFFF_FFFF, 32'd2, 1'b1, 1'b1, 1'b1,
                 32'h8000_0000, 32'h8000_0000);
        add_item(3'd1, 4'd1, 32'h7FFF_FFFF, 32'd3, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0);
        add_item(3'd1, 4'd1, 32'h8000_0000, 32'd4, 1'b1, 1'b1, 1'b0, 32'd0, 32'd0);
        // forced update past max_interval, and exactly at it
        add_item(3'd2, 4'd0, 32'h0000_0000, 32'd10001, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0);
        add_item(3'd2, 4'd0, 32'h0000_0000, 32'd20001, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd2, 4'd1, 32'h0005_0000, 32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1, 32'd0, 32'd0);
        add_item(3'd2, 4'd1, 32'h0006_0000, 32'h0000_0010, 1'b1, 1'b1, 1'b1,
                 32'd2048, 32'd64);
        add_item(3'd2, 4'd2, 32'hFFFF_FFF9, 32'd2, 1'b1, 1'b1, 1'b1,
                 32'hFFFF_FFFD, 32'hFFFF_FFFF);
        // dead-band and minimum interval
        add_write(CFG_PRECISION, 32'h0001_0000);
        add_write(CFG_MIN_INTERVAL, 32'd50);
        add_item(3'd3, 4'd0, 32'h0001_0000, 32'd40, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd3, 4'd0, 32'h0001_0000, 32'd60, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd3, 4'd0, 32'h0001_0001, 32'd60, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd3, 4'd0, 32'hFFFE_FFFF, 32'd200, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);
        // all registers at their top: nothing can update
        add_write(CFG_MIN_INTERVAL, 32'hFFFF_FFFF);
        add_write(CFG_MAX_INTERVAL, 32'hFFFF_FFFF);
        add_write(CFG_PRECISION, 32'h7FFF_FFFF);
        add_item(3'd3, 4'd1, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
        // all registers at zero: any elapsed time updates
        add_write(CFG_MAX_INTERVAL, 32'd0);
        add_write(CFG_MIN_INTERVAL, 32'd0);
        add_write(CFG_PRECISION, 32'd0);
        add_item(3'd3, 4'd1, 32'h0000_0000, 32'd0, 1'b1, 1'b0, 1'b0, 32'd0, 32'd0);
        add_item(3'd3, 4'd1, 32'h0000_0003, 32'd3, 1'b0, 1'b0, 1'b0, 32'd0, 32'd0);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_write)
            begin
                settle();
                write_reg(directed_rows[i].reg_idx, directed_rows[i].reg_val);
            end
            else
                send_sample(directed_rows[i].grp, directed_rows[i].chn, directed_rows[i].val,
                            directed_rows[i].stamp, directed_rows[i].known,
                            directed_rows[i].want);
        end

        for (int ph = 0; ph < 3; ph++)
        begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 85 : 0;
            recv_idle_pct = (ph == 0) ? 85 : (ph == 1) ? 12 : 0;
            for (int sub = 0; sub < 4; sub++)
            begin
                settle();
                apply_profile(cfg_profile_t'((ph * 4 + sub) % 5));
                for (int n = 0; n < 96; n++)
                begin
                    // occasional hold-off until the block has fully drained
                    if ($urandom_range(63) == 0)
                        wait_results();
                    random_item();
                end
            end
        end

        settle();
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/srce_pkg.sv
rtl/core/srce_div.sv
rtl/core/sample_rate_of_change_estimator_unit.sv
bench/tb_sample_rate_of_change_estimator_unit.sv
